// ----- rtl/crt_pkg.sv -----
package crt_pkg;

	// configuration port geometry
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// register indexes
	localparam logic [1:0] REG_ACK_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_RETRY_BASE  = 2'd1;
	localparam logic [1:0] REG_BACKOFF_CAP = 2'd2;
	localparam logic [1:0] REG_RETRY_LIMIT = 2'd3;

	// register reset values
	localparam logic [15:0] RST_ACK_TIMEOUT = 16'd5000;
	localparam logic [13:0] RST_RETRY_BASE  = 14'd1000;
	localparam logic [15:0] RST_BACKOFF_CAP = 16'd16000;
	localparam logic [3:0]  RST_RETRY_LIMIT = 4'd5;

	// highest retry count
	localparam logic [3:0] RETRY_MAX = 4'd15;

	// action codes
	localparam logic [2:0] ACT_ADD     = 3'd0;
	localparam logic [2:0] ACT_FETCH   = 3'd1;
	localparam logic [2:0] ACT_MARK    = 3'd2;
	localparam logic [2:0] ACT_ACK     = 3'd3;
	localparam logic [2:0] ACT_CLEAR   = 3'd4;
	localparam logic [2:0] ACT_TIMEOUT = 3'd5;
	localparam logic [2:0] ACT_RETRY   = 3'd6;
	localparam logic [2:0] ACT_REMOVE  = 3'd7;

	// status codes
	localparam logic [2:0] STAT_DONE    = 3'd0;
	localparam logic [2:0] STAT_DUP     = 3'd1;
	localparam logic [2:0] STAT_FREE    = 3'd2;
	localparam logic [2:0] STAT_EVICT   = 3'd3;
	localparam logic [2:0] STAT_ACKED   = 3'd4;
	localparam logic [2:0] STAT_NOMATCH = 3'd5;
	localparam logic [2:0] STAT_NONE    = 3'd6;

	typedef struct packed {
		logic [15:0] ack_wait_ms;
		logic [13:0] retry_base_ms;
		logic [15:0] backoff_cap_ms;
		logic [3:0]  retry_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  node;
		logic [47:0] command;
		logic [3:0]  slot;
		logic [47:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [3:0]  found_slot;
		logic [7:0]  found_node;
		logic [47:0] found_command;
		logic [3:0]  found_retries;
		logic [4:0]  node_pending;
		logic [4:0]  total_pending;
		logic [4:0]  dropped;
	} result_t;

	// one table entry as held in the store
	typedef struct packed {
		logic [7:0]  node;
		logic [47:0] command;
		logic [3:0]  retries;
		logic [47:0] next_retry;
		logic [47:0] sent_at;
	} rec_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage

// ----- rtl/crt_regs.sv -----
module crt_regs import crt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_wait_ms    <= RST_ACK_TIMEOUT;
			cfg_q.retry_base_ms  <= RST_RETRY_BASE;
			cfg_q.backoff_cap_ms <= RST_BACKOFF_CAP;
			cfg_q.retry_limit    <= RST_RETRY_LIMIT;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_ACK_TIMEOUT: cfg_q.ack_wait_ms    <= pwdata[15:0];
				REG_RETRY_BASE:  cfg_q.retry_base_ms  <= pwdata[13:0];
				REG_BACKOFF_CAP: cfg_q.backoff_cap_ms <= pwdata[15:0];
				REG_RETRY_LIMIT: cfg_q.retry_limit    <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[3:2])
			REG_ACK_TIMEOUT: prdata = {16'd0, cfg_q.ack_wait_ms};
			REG_RETRY_BASE:  prdata = {18'd0, cfg_q.retry_base_ms};
			REG_BACKOFF_CAP: prdata = {16'd0, cfg_q.backoff_cap_ms};
			REG_RETRY_LIMIT: prdata = {28'd0, cfg_q.retry_limit};
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- rtl/crt_store.sv -----
module crt_store import crt_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  rec_t          wdata,
	input  logic          re,
	input  logic [IW-1:0] raddr,
	output rec_t          rdata
);

	rec_t mem [DEPTH];
	rec_t rdata_q;

	assign rdata = rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// ----- rtl/command_retry_table.sv -----
// Pending command table with acknowledgement retry handling.
// Item channel: drive item and raise start; the item is taken at a clock
// edge where start is high and busy is low. One item is worked at a time.
// Result channel: every item gives one result on result, shown for exactly
// one cycle with result_valid high; the receiver cannot stall it.
// Busy drops in the cycle the result is shown, so a new item can be taken
// while the result is shown, but not before. The scan reads each slot of
// the entry store once through its single read port, checks it in stage 1
// and writes it back from the stage 2 registers.
// Configuration: APB-style port, four registers at byte addresses 0, 4, 8
// and 12; pready is always high; write only while busy is low.
// Reset: arst_n clears all pending and waiting flags at once and restores
// the register defaults; the store contents are don't-care until written.
module command_retry_table import crt_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	output logic              result_valid,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW:0] SLOTS_C = (IW + 1)'(SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	cfg_t   cfg;
	state_t state_q, state_nx;
	item_t  item_q;

	logic          issue, fin;
	logic [IW:0]   rd_cnt_q;
	logic [SLOTS-1:0] pend_q, wait_q;

	// store ports
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	rec_t          mem_wdata;
	rec_t          rd_rec;

	// stage 1 and 2 control
	logic          s1_valid_s1;
	logic [IW-1:0] idx_s1;
	logic          s2_valid_s2;
	logic [IW-1:0] idx_s2;
	rec_t          rec_s2;
	logic          new_pend_s2, new_wait_s2, timed_s2, markw_s2, drop_s2;
	logic [3:0]    new_ret_s2;
	logic [15:0]   delay_s2;

	// stage 1 decisions
	logic          pend_c, wait_c, nmatch_c, cmatch_c, tmo_c, drop_c;
	logic          new_pend_c, new_wait_c, timed_c, markw_c;
	logic [3:0]    new_ret_c;
	logic [28:0]   shifted_c;
	logic [15:0]   delay_c;
	logic [47:0]   elapsed_c;
	logic          slot_hit_c, take_sel_c;

	// scan accumulators
	logic          dup_q, free_q, min_any_q, min_nmatch_q, ack_q, ok_q, sel_q;
	logic [IW-1:0] dup_idx_q, free_idx_q, min_idx_q, ack_idx_q, sel_idx_q;
	logic [47:0]   min_nr_q, sel_nr_q;
	logic [7:0]    sel_node_q;
	logic [47:0]   sel_cmd_q;
	logic [3:0]    sel_ret_q;
	logic [CW-1:0] tot_q, npend_q, drop_cnt_q;

	// finish step
	logic          fill_c;
	logic [IW-1:0] fill_idx_c;
	result_t       res_c, result_q;
	logic          result_valid_q;

	crt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crt_store #(
		.DEPTH (SLOTS),
		.IW    (IW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (issue),
		.raddr (rd_cnt_q[IW-1:0]),
		.rdata (rd_rec)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (start) state_nx = ST_SCAN;
			ST_SCAN: if (s2_valid_s2 && idx_s2 == LAST_IDX) state_nx = ST_FIN;
			ST_FIN:  state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy  = (state_q != ST_IDLE);
		issue = (state_q == ST_SCAN) && (rd_cnt_q < SLOTS_C);
		fin   = (state_q == ST_FIN);
	end

	// item latch and read counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
		end else if (state_q == ST_IDLE && start) begin
			rd_cnt_q <= '0;
		end else if (issue) begin
			rd_cnt_q <= rd_cnt_q + (IW + 1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			item_q <= item;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			s2_valid_s2 <= 1'b0;
		end else begin
			s1_valid_s1 <= issue;
			s2_valid_s2 <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q[IW-1:0];
	end

	// stage 1: per-entry check on the read data
	always_comb begin
		pend_c     = pend_q[idx_s1];
		wait_c     = wait_q[idx_s1];
		nmatch_c   = (rd_rec.node == item_q.node);
		cmatch_c   = (rd_rec.command == item_q.command);
		elapsed_c  = item_q.now_ms - rd_rec.sent_at;
		tmo_c      = pend_c && wait_c && (rd_rec.sent_at != '0) &&
		             (elapsed_c >= {32'd0, cfg.ack_wait_ms});
		new_ret_c  = (rd_rec.retries == RETRY_MAX) ? RETRY_MAX : rd_rec.retries + 4'd1;
		shifted_c  = 29'(cfg.retry_base_ms) << (new_ret_c - 4'd1);
		delay_c    = (shifted_c > {13'd0, cfg.backoff_cap_ms}) ?
		             cfg.backoff_cap_ms : shifted_c[15:0];
		drop_c     = (new_ret_c >= cfg.retry_limit);
		slot_hit_c = (32'(item_q.slot) == 32'(idx_s1)) && pend_c;
		new_pend_c = pend_c;
		new_wait_c = wait_c;
		timed_c    = 1'b0;
		markw_c    = 1'b0;
		take_sel_c = 1'b0;
		case (item_q.action)
			ACT_FETCH: begin
				take_sel_c = pend_c && nmatch_c && !wait_c &&
				             (!sel_q || rd_rec.next_retry < sel_nr_q);
			end
			ACT_MARK: begin
				if (slot_hit_c) begin
					new_wait_c = 1'b1;
					markw_c    = 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (slot_hit_c) begin
					new_pend_c = 1'b0;
					new_wait_c = 1'b0;
				end
			end
			ACT_ACK: begin
				if (pend_c && nmatch_c && cmatch_c && !ack_q) begin
					new_pend_c = 1'b0;
					new_wait_c = 1'b0;
				end
			end
			ACT_CLEAR: begin
				if (pend_c && nmatch_c) new_pend_c = 1'b0;
			end
			ACT_TIMEOUT, ACT_RETRY: begin
				if (tmo_c) begin
					timed_c    = 1'b1;
					new_wait_c = 1'b0;
					new_pend_c = !drop_c;
				end else if (item_q.action == ACT_RETRY) begin
					take_sel_c = pend_c && !wait_c &&
					             (item_q.now_ms >= rd_rec.next_retry) &&
					             (!sel_q || rd_rec.next_retry < sel_nr_q);
				end
			end
			default: ;
		endcase
	end

	// stage 1 accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q     <= 1'b0;
			free_q    <= 1'b0;
			min_any_q <= 1'b0;
			ack_q     <= 1'b0;
			ok_q      <= 1'b0;
			sel_q     <= 1'b0;
		end else if (state_q == ST_IDLE && start) begin
			dup_q     <= 1'b0;
			free_q    <= 1'b0;
			min_any_q <= 1'b0;
			ack_q     <= 1'b0;
			ok_q      <= 1'b0;
			sel_q     <= 1'b0;
		end else if (s1_valid_s1) begin
			if (item_q.action == ACT_ADD && pend_c && nmatch_c && cmatch_c) dup_q <= 1'b1;
			if (!pend_c) free_q <= 1'b1;
			min_any_q <= 1'b1;
			if (item_q.action == ACT_ACK && pend_c && nmatch_c && cmatch_c) ack_q <= 1'b1;
			if ((item_q.action == ACT_MARK || item_q.action == ACT_REMOVE) && slot_hit_c) begin
				ok_q <= 1'b1;
			end
			if (take_sel_c) sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1) begin
			if (item_q.action == ACT_ADD && pend_c && nmatch_c && cmatch_c && !dup_q) begin
				dup_idx_q <= idx_s1;
			end
			if (!pend_c && !free_q) free_idx_q <= idx_s1;
			if (!min_any_q || rd_rec.next_retry < min_nr_q) begin
				min_idx_q    <= idx_s1;
				min_nr_q     <= rd_rec.next_retry;
				min_nmatch_q <= nmatch_c;
			end
			if (item_q.action == ACT_ACK && pend_c && nmatch_c && cmatch_c && !ack_q) begin
				ack_idx_q <= idx_s1;
			end
			if (take_sel_c) begin
				sel_idx_q  <= idx_s1;
				sel_nr_q   <= rd_rec.next_retry;
				sel_node_q <= rd_rec.node;
				sel_cmd_q  <= rd_rec.command;
				sel_ret_q  <= rd_rec.retries;
			end
		end
	end

	// stage 2 registers
	always_ff @(posedge clk) begin
		idx_s2      <= idx_s1;
		rec_s2      <= rd_rec;
		new_pend_s2 <= new_pend_c;
		new_wait_s2 <= new_wait_c;
		timed_s2    <= timed_c;
		markw_s2    <= markw_c;
		drop_s2     <= timed_c && drop_c;
		new_ret_s2  <= new_ret_c;
		delay_s2    <= delay_c;
	end

	// write back: stage 2 update or the fill of an add
	always_comb begin
		fill_c     = fin && item_q.action == ACT_ADD && !dup_q;
		fill_idx_c = free_q ? free_idx_q : min_idx_q;
		mem_wdata  = rec_s2;
		if (timed_s2) begin
			mem_wdata.retries    = new_ret_s2;
			mem_wdata.next_retry = item_q.now_ms + {32'd0, delay_s2};
			mem_wdata.sent_at    = '0;
		end
		if (markw_s2) mem_wdata.sent_at = item_q.now_ms;
		mem_we    = s2_valid_s2 && (timed_s2 || markw_s2);
		mem_waddr = idx_s2;
		if (fill_c) begin
			mem_we    = 1'b1;
			mem_waddr = fill_idx_c;
			mem_wdata = '{node: item_q.node, command: item_q.command,
			              retries: 4'd0, next_retry: 48'd0, sent_at: 48'd0};
		end
	end

	// entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			wait_q <= '0;
		end else if (fill_c) begin
			pend_q[fill_idx_c] <= 1'b1;
			wait_q[fill_idx_c] <= 1'b0;
		end else if (s2_valid_s2) begin
			pend_q[idx_s2] <= new_pend_s2;
			wait_q[idx_s2] <= new_wait_s2;
		end
	end

	// stage 2 counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q      <= '0;
			npend_q    <= '0;
			drop_cnt_q <= '0;
		end else if (state_q == ST_IDLE && start) begin
			tot_q      <= '0;
			npend_q    <= '0;
			drop_cnt_q <= '0;
		end else if (s2_valid_s2) begin
			tot_q      <= tot_q + CW'(new_pend_s2);
			npend_q    <= npend_q + CW'(new_pend_s2 && rec_s2.node == item_q.node);
			drop_cnt_q <= drop_cnt_q + CW'(drop_s2);
		end
	end

	// result assembly
	always_comb begin
		res_c               = '0;
		res_c.total_pending = 5'(tot_q);
		res_c.node_pending  = 5'(npend_q);
		res_c.dropped       = 5'(drop_cnt_q);
		case (item_q.action)
			ACT_ADD: begin
				if (dup_q) begin
					res_c.status     = STAT_DUP;
					res_c.found_slot = 4'(dup_idx_q);
				end else if (free_q) begin
					res_c.status        = STAT_FREE;
					res_c.found_slot    = 4'(free_idx_q);
					res_c.total_pending = 5'(tot_q + CW'(1));
					res_c.node_pending  = 5'(npend_q + CW'(1));
				end else begin
					res_c.status       = STAT_EVICT;
					res_c.found_slot   = 4'(min_idx_q);
					res_c.node_pending = 5'(npend_q + CW'(!min_nmatch_q));
				end
			end
			ACT_FETCH, ACT_RETRY: begin
				res_c.status = sel_q ? STAT_DONE : STAT_NONE;
				if (sel_q) begin
					res_c.found         = 1'b1;
					res_c.found_slot    = 4'(sel_idx_q);
					res_c.found_node    = sel_node_q;
					res_c.found_command = sel_cmd_q;
					res_c.found_retries = sel_ret_q;
				end
			end
			ACT_MARK, ACT_REMOVE: begin
				res_c.status     = ok_q ? STAT_DONE : STAT_NOMATCH;
				res_c.found_slot = item_q.slot;
			end
			ACT_ACK: begin
				res_c.status     = ack_q ? STAT_ACKED : STAT_NOMATCH;
				res_c.found_slot = ack_q ? 4'(ack_idx_q) : 4'd0;
			end
			default: res_c.status = STAT_DONE;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) result_q <= res_c;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	a_result_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_FIN))
		else $error("result shown without a finish step");

	a_stage2_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_s2 |-> state_q == ST_SCAN)
		else $error("stage 2 active outside the scan");

	a_fill_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && mem_we) |-> item_q.action == ACT_ADD)
		else $error("fill write for an action other than add");

	a_stage_idx_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && s2_valid_s2) |-> idx_s1 != idx_s2)
		else $error("read and write back on the same slot");
`endif

endmodule
